[hw/rtl/cps3d_pkg.sv]
package cps3d_pkg;
  localparam int unsigned CoordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned TBits = 16;

  typedef enum logic [1:0] {
    WhereStart    = 2'd0,
    WhereEnd      = 2'd1,
    WhereInterior = 2'd2
  } where_e;
endpackage

[hw/rtl/closest_point_on_segment_3d_core.sv]
// closest point on a 3-d segment, fully pipelined
// pipeline: TBits + 7 stages from input request to result
// throughput: one request per cycle while not stalled; each division step is its own stage
// a stall holds the whole pipeline in place, nothing is lost or repeated
// reset: asynchronous active-low rst_ni clears every stage valid bit
module closest_point_on_segment_3d_core #(
  parameter int unsigned COORD_BITS = cps3d_pkg::CoordBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // query_x, query_y, query_z, start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // near_x, near_y, near_z, where_found, degenerate
  output logic [((3*COORD_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned TB = cps3d_pkg::TBits;
  localparam int unsigned OW = ((3*CB+3+7)/8)*8;
  localparam int unsigned NS = TB + 7;

  typedef struct packed {
    logic signed [2:0][CB-1:0] a;
    logic signed [2:0][CB-1:0] b;
    logic signed [2:0][DW-1:0] d;
    logic signed [2:0][DW-1:0] e;
    logic signed [2:0][PW-1:0] pn;
    logic signed [2:0][PW-1:0] pd;
    logic signed [SW-1:0] num;
    logic signed [SW-1:0] den;
    logic [SW-1:0] rem;
    logic [TB-1:0] tq;
    logic [1:0] where;
    logic degen;
    logic signed [2:0][DW+TB:0] off;
  } stage_t;

  logic   adv;
  logic   [NS-1:0] vld_q;
  stage_t st_q [NS];
  stage_t st_d [NS];

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < NS; s++) st_q[s] <= st_d[s];
    end
  end

  // stage 0: differences
  always_comb begin
    st_d[0] = '0;
    for (int i = 0; i < 3; i++) begin
      st_d[0].a[i] = s_axis_tdata[(3+i)*CB +: CB];
      st_d[0].b[i] = s_axis_tdata[(6+i)*CB +: CB];
      st_d[0].d[i] = DW'($signed(s_axis_tdata[(6+i)*CB +: CB]))
                   - DW'($signed(s_axis_tdata[(3+i)*CB +: CB]));
      st_d[0].e[i] = DW'($signed(s_axis_tdata[i*CB +: CB]))
                   - DW'($signed(s_axis_tdata[(3+i)*CB +: CB]));
    end
  end

  // stage 1: products
  always_comb begin
    st_d[1] = st_q[0];
    for (int i = 0; i < 3; i++) begin
      st_d[1].pn[i] = PW'($signed(st_q[0].e[i])) * PW'($signed(st_q[0].d[i]));
      st_d[1].pd[i] = PW'($signed(st_q[0].d[i])) * PW'($signed(st_q[0].d[i]));
    end
  end

  // stage 2: sums
  always_comb begin
    st_d[2] = st_q[1];
    st_d[2].num = SW'($signed(st_q[1].pn[0])) + SW'($signed(st_q[1].pn[1]))
                + SW'($signed(st_q[1].pn[2]));
    st_d[2].den = SW'($signed(st_q[1].pd[0])) + SW'($signed(st_q[1].pd[1]))
                + SW'($signed(st_q[1].pd[2]));
  end

  // stage 3: classify
  always_comb begin
    st_d[3] = st_q[2];
    st_d[3].rem = st_q[2].num;
    st_d[3].tq = '0;
    st_d[3].degen = (st_q[2].den == '0);
    if (st_q[2].den == '0 || st_q[2].num <= 0) begin
      st_d[3].where = cps3d_pkg::WhereStart;
    end else if (st_q[2].num >= st_q[2].den) begin
      st_d[3].where = cps3d_pkg::WhereEnd;
    end else begin
      st_d[3].where = cps3d_pkg::WhereInterior;
    end
  end

  // stages 4 .. TB+3: one restoring division step each
  for (genvar k = 0; k < TB; k++) begin : g_div
    always_comb begin
      logic [SW:0] r2;
      r2 = {st_q[3+k].rem, 1'b0};
      st_d[4+k] = st_q[3+k];
      st_d[4+k].tq = {st_q[3+k].tq[TB-2:0], 1'b0};
      if (r2 >= {1'b0, st_q[3+k].den}) begin
        r2 = r2 - {1'b0, st_q[3+k].den};
        st_d[4+k].tq[0] = 1'b1;
      end
      st_d[4+k].rem = r2[SW-1:0];
    end
  end

  // offset products
  always_comb begin
    st_d[TB+4] = st_q[TB+3];
    for (int i = 0; i < 3; i++) begin
      st_d[TB+4].off[i] = (DW+TB+1)'($signed(st_q[TB+3].d[i]))
                        * $signed({1'b0, st_q[TB+3].tq});
    end
  end

  // add offset, interior points only
  always_comb begin
    st_d[TB+5] = st_q[TB+4];
    if (st_q[TB+4].where == cps3d_pkg::WhereInterior) begin
      for (int i = 0; i < 3; i++) begin
        st_d[TB+5].a[i] = st_q[TB+4].a[i] + CB'($signed(st_q[TB+4].off[i]) >>> TB);
      end
    end
  end

  // select result
  always_comb begin
    st_d[TB+6] = st_q[TB+5];
    if (st_q[TB+5].where == cps3d_pkg::WhereEnd) begin
      st_d[TB+6].a = st_q[TB+5].b;
    end
  end

  assign m_axis_tdata = OW'({st_q[TB+6].degen, st_q[TB+6].where,
                             st_q[TB+6].a[2], st_q[TB+6].a[1], st_q[TB+6].a[0]});
endmodule

[test/testbench.sv]
module testbench;
  localparam int unsigned CB = cps3d_pkg::CoordBits;
  localparam int unsigned InW = ((9 * CB + 7) / 8) * 8;
  localparam int unsigned OutW = ((3 * CB + 3 + 7) / 8) * 8;
  localparam int unsigned PipeDepth = 23;

  typedef struct packed {
    logic [CB-1:0] z;
    logic [CB-1:0] y;
    logic [CB-1:0] x;
  } vec_t;

  typedef struct packed {
    vec_t q;
    vec_t a;
    vec_t b;
  } query_t;

  typedef struct {
    logic [CB-1:0] nx;
    logic [CB-1:0] ny;
    logic [CB-1:0] nz;
    cps3d_pkg::where_e where;
    logic degen;
  } near_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;

  query_t pending_q[$];
  near_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_send = 1'b0;
  bit in_done = 1'b0;

  closest_point_on_segment_3d_core uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [InW-1:0] pack_query(query_t r);
    logic [InW-1:0] v;
    v = '0;
    v[CB*0 +: CB] = r.q.x;
    v[CB*1 +: CB] = r.q.y;
    v[CB*2 +: CB] = r.q.z;
    v[CB*3 +: CB] = r.a.x;
    v[CB*4 +: CB] = r.a.y;
    v[CB*5 +: CB] = r.a.z;
    v[CB*6 +: CB] = r.b.x;
    v[CB*7 +: CB] = r.b.y;
    v[CB*8 +: CB] = r.b.z;
    return v;
  endfunction

  function automatic near_t nearest_point(query_t r);
    logic signed [CB-1:0] p[3], a[3], b[3];
    logic signed [CB:0] d[3], e[3];
    logic signed [127:0] num, den, rem, off;
    logic [cps3d_pkg::TBits-1:0] tq;
    near_t o;
    p[0] = r.q.x; p[1] = r.q.y; p[2] = r.q.z;
    a[0] = r.a.x; a[1] = r.a.y; a[2] = r.a.z;
    b[0] = r.b.x; b[1] = r.b.y; b[2] = r.b.z;
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = (CB + 1)'(b[i]) - (CB + 1)'(a[i]);
      e[i] = (CB + 1)'(p[i]) - (CB + 1)'(a[i]);
      num += 128'(e[i]) * 128'(d[i]);
      den += 128'(d[i]) * 128'(d[i]);
    end
    o.degen = (den == 0);
    o.nx = a[0]; o.ny = a[1]; o.nz = a[2];
    o.where = cps3d_pkg::WhereStart;
    if (den != 0 && num > 0) begin
      if (num >= den) begin
        o.nx = b[0]; o.ny = b[1]; o.nz = b[2];
        o.where = cps3d_pkg::WhereEnd;
      end else begin
        rem = num;
        tq = '0;
        for (int k = 0; k < cps3d_pkg::TBits; k++) begin
          rem = rem <<< 1;
          tq = tq << 1;
          if (rem >= den) begin
            rem -= den;
            tq[0] = 1'b1;
          end
        end
        off = (128'(d[0]) * $signed({112'd0, tq})) >>> cps3d_pkg::TBits;
        o.nx = a[0] + off[CB-1:0];
        off = (128'(d[1]) * $signed({112'd0, tq})) >>> cps3d_pkg::TBits;
        o.ny = a[1] + off[CB-1:0];
        off = (128'(d[2]) * $signed({112'd0, tq})) >>> cps3d_pkg::TBits;
        o.nz = a[2] + off[CB-1:0];
        o.where = cps3d_pkg::WhereInterior;
      end
    end
    return o;
  endfunction

  function automatic logic [CB-1:0] rand_coord(int mode);
    logic [CB-1:0] v;
    case (mode)
      0: v = $urandom;
      1: v = CB'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: v = CB'($signed($urandom_range(0, 200)) - 100);
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(CB-1){1'b0}}};
          1: v = {1'b0, {(CB-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic query_t rand_query();
    query_t r;
    int mode;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
    r.q = {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    r.a = {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    r.b = {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    case ($urandom_range(0, 9))
      0: r.b = r.a;
      1: r.q = r.a;
      2: r.q = r.b;
      3: r.b = {r.a.z, r.a.y + CB'($urandom_range(1, 3)), r.a.x};
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((!s_axis_tvalid || in_done) && pending_q.size() > 0 && !hold_send
          && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_query(pending_q[0]);
      end else if (!s_axis_tvalid || in_done) begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    near_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[CB*0 +: CB] !== want.nx) begin
          $error("near_x expected %h actual %h", want.nx, m_axis_tdata[CB*0 +: CB]);
          errors++;
        end
        if (m_axis_tdata[CB*1 +: CB] !== want.ny) begin
          $error("near_y expected %h actual %h", want.ny, m_axis_tdata[CB*1 +: CB]);
          errors++;
        end
        if (m_axis_tdata[CB*2 +: CB] !== want.nz) begin
          $error("near_z expected %h actual %h", want.nz, m_axis_tdata[CB*2 +: CB]);
          errors++;
        end
        if (m_axis_tdata[CB*3 +: 2] !== want.where) begin
          $error("where_found expected %0d actual %0d", want.where,
                 m_axis_tdata[CB*3 +: 2]);
          errors++;
        end
        if (m_axis_tdata[CB*3+2] !== want.degen) begin
          $error("degenerate expected %0d actual %0d", want.degen, m_axis_tdata[CB*3+2]);
          errors++;
        end
      end
    end
    in_done = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_done) begin
      expected_q.push_back(nearest_point(pending_q.pop_front()));
    end
  end

  function automatic query_t mk(vec_t q, vec_t a, vec_t b);
    query_t r;
    r.q = q; r.a = a; r.b = b;
    return r;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    vec_t zero, one, mn, mx;
    zero = '0;
    one = {32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    mn = {3{32'h8000_0000}};
    mx = {3{32'h7fff_ffff}};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // degenerate, before start, past end, midpoint, tiny t, extremes
    pending_q.push_back(mk(one, zero, zero));
    pending_q.push_back(mk(mn, mx, mx));
    pending_q.push_back(mk({3{32'hffff_0000}}, zero, one));
    pending_q.push_back(mk(zero, zero, one));
    pending_q.push_back(mk({3{32'h0002_0000}}, zero, one));
    pending_q.push_back(mk(one, zero, one));
    pending_q.push_back(mk({3{32'h0000_8000}}, zero, one));
    pending_q.push_back(mk({3{32'h0000_8000}}, one, zero));
    pending_q.push_back(mk({32'd0, 32'd0, 32'd1}, zero, {32'd0, 32'd0, 32'h7fff_ffff}));
    pending_q.push_back(mk(mx, mn, mx));
    pending_q.push_back(mk(mn, mn, mx));
    pending_q.push_back(mk(zero, mn, mx));
    pending_q.push_back(mk(zero, mx, mn));
    pending_q.push_back(mk(mx, mx, mn));
    pending_q.push_back(mk(mn, mx, mn));
    pending_q.push_back(mk({3{32'hffff_ffff}}, mn, mx));
    pending_q.push_back(mk(zero, {32'd0, 32'd0, 32'hffff_fffd}, {32'd0, 32'd0, 32'd3}));
    pending_q.push_back(mk({3{32'h5555_5555}}, {3{32'haaaa_aaaa}}, {3{32'h1234_5678}}));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 66 : 0;
      recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 34 : 0;
      if (ph == 3) send_idle_pct = 34;
      for (int n = 0; n < 400; n++) pending_q.push_back(rand_query());
      if (ph == 1) begin
        while (pending_q.size() > 200) @(posedge clk_i);
        hold_send = 1'b1;
        while (s_axis_tvalid || expected_q.size() > 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      drain();
    end
    recv_stall_pct = 0;
    repeat (PipeDepth + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end
endmodule

[sim.f]
hw/rtl/cps3d_pkg.sv
hw/rtl/closest_point_on_segment_3d_core.sv
test/testbench.sv
